// ----- hw/rtl/cau_pkg.sv -----
// Shared constants for the complex arithmetic unit: default widths and operation codes.
package cau_pkg;

	localparam int WORD_BITS = 16;
	localparam int FRAC_BITS = 8;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

endpackage

// ----- hw/rtl/complex_arithmetic_unit_core.sv -----
// Complex add/sub/mul/div unit in signed fixed point, fully pipelined.
// Stages: product stage, sum stage,
// one divider stage per quotient bit (WORD_BITS + 2), output register.
// Throughput: one transfer per cycle; any stall on the output holds the whole pipeline.
// Reset clears the valid bits only; data registers are not reset.
module complex_arithmetic_unit_core #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
	localparam int IN_W  = ((2 + 4 * WORD_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * WORD_BITS + 2 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // op, a_re, a_im, b_re, b_im
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata   // res_re, res_im, div_by_zero, saturated
);

	localparam int W  = WORD_BITS;
	localparam int PW = 2 * W + 1;
	localparam int NS = W + 2;
	localparam int TW = 2 * W + 3;
	localparam logic signed [PW-1:0] MAXV = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW-1:0] MINV = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [NS-1:0] HALF = NS'(1) << (W - 1);

	function automatic logic [W:0] clip_signed(input logic signed [PW-1:0] v);
		logic [W:0] r;
		if (v > MAXV) begin
			r = {1'b1, MAXV[W-1:0]};
		end else if (v < MINV) begin
			r = {1'b1, MINV[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	function automatic logic [W:0] clip_mag(input logic neg, input logic [NS-1:0] q);
		logic [W:0]    r;
		logic [NS-1:0] m;
		if (neg) begin
			m = (q > HALF) ? HALF : q;
			m = -m;
			r = {(q > HALF), m[W-1:0]};
		end else begin
			m = (q > HALF - 1'b1) ? HALF - 1'b1 : q;
			r = {(q > HALF - 1'b1), m[W-1:0]};
		end
		return r;
	endfunction

	logic en;
	logic out_valid_q;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	logic [1:0]          op;
	logic signed [W-1:0] ar, ai, br, bi;
	assign op = s_axis_tdata[1:0];
	assign ar = s_axis_tdata[2 +: W];
	assign ai = s_axis_tdata[2 + W +: W];
	assign br = s_axis_tdata[2 + 2 * W +: W];
	assign bi = s_axis_tdata[2 + 3 * W +: W];

	// stage 1: products and part-wise add/sub
	logic                  v_s1;
	logic [1:0]            op_s1;
	logic signed [2*W-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [W:0]     as_re_s1, as_im_s1;
	logic                  dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			ac_s1 <= ar * br;
			bd_s1 <= ai * bi;
			ad_s1 <= ar * bi;
			bc_s1 <= ai * br;
			cc_s1 <= br * br;
			dd_s1 <= bi * bi;
			if (op == cau_pkg::OP_SUB) begin
				as_re_s1 <= {ar[W-1], ar} - {br[W-1], br};
				as_im_s1 <= {ai[W-1], ai} - {bi[W-1], bi};
			end else begin
				as_re_s1 <= {ar[W-1], ar} + {br[W-1], br};
				as_im_s1 <= {ai[W-1], ai} + {bi[W-1], bi};
			end
			dz_s1 <= (br == '0) && (bi == '0);
		end
	end

	// stage 2: sums of products, floor shift and clip for non-divide ops
	logic signed [PW-1:0] acx, bdx, adx, bcx;
	logic signed [PW-1:0] val_re, val_im, nr, ni;
	logic [W:0]           cl_re, cl_im;

	assign acx = {ac_s1[2*W-1], ac_s1};
	assign bdx = {bd_s1[2*W-1], bd_s1};
	assign adx = {ad_s1[2*W-1], ad_s1};
	assign bcx = {bc_s1[2*W-1], bc_s1};
	assign nr  = acx + bdx;
	assign ni  = bcx - adx;

	always_comb begin
		if (op_s1 == cau_pkg::OP_MUL) begin
			val_re = (acx - bdx) >>> FRAC_BITS;
			val_im = (adx + bcx) >>> FRAC_BITS;
		end else begin
			val_re = {{(PW-W-1){as_re_s1[W]}}, as_re_s1};
			val_im = {{(PW-W-1){as_im_s1[W]}}, as_im_s1};
		end
		cl_re = clip_signed(val_re);
		cl_im = clip_signed(val_im);
	end

	logic                  v_s2;
	logic                  re_neg_s2, im_neg_s2;
	logic [PW-1:0]         re_mag_s2, im_mag_s2;
	logic [2*W-1:0]        den_s2;
	logic [TW-1:0]         tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_neg_s2 <= nr[PW-1];
			im_neg_s2 <= ni[PW-1];
			re_mag_s2 <= nr[PW-1] ? PW'(-nr) : PW'(nr);
			im_mag_s2 <= ni[PW-1] ? PW'(-ni) : PW'(ni);
			den_s2    <= cc_s1[2*W-1:0] + dd_s1[2*W-1:0];
			// tag: {is_div, div_by_zero, saturated, res_im, res_re}
			tag_s2    <= {(op_s1 == cau_pkg::OP_DIV), dz_s1, cl_re[W] | cl_im[W],
				cl_im[W-1:0], cl_re[W-1:0]};
		end
	end

	logic           dv_valid;
	logic [NS-1:0]  dv_re_quo, dv_im_quo;
	logic           dv_re_neg, dv_im_neg;
	logic [TW-1:0]  dv_tag;

	cau_div #(
		.WORD_BITS (WORD_BITS),
		.FRAC_BITS (FRAC_BITS),
		.TAG_BITS  (TW)
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s2),
		.in_re_neg  (re_neg_s2),
		.in_re_mag  (re_mag_s2),
		.in_im_neg  (im_neg_s2),
		.in_im_mag  (im_mag_s2),
		.in_den     (den_s2),
		.in_tag     (tag_s2),
		.out_valid  (dv_valid),
		.out_re_quo (dv_re_quo),
		.out_re_neg (dv_re_neg),
		.out_im_quo (dv_im_quo),
		.out_im_neg (dv_im_neg),
		.out_tag    (dv_tag)
	);

	// output stage: pick divide result or carried result
	logic [W:0]         qd_re, qd_im;
	logic [OUT_W-1:0]   res_word;

	always_comb begin
		qd_re = clip_mag(dv_re_neg, dv_re_quo);
		qd_im = clip_mag(dv_im_neg, dv_im_quo);
		if (!dv_tag[TW-1]) begin
			res_word = OUT_W'({dv_tag[2*W], 1'b0, dv_tag[2*W-1:0]});
		end else if (dv_tag[2*W+1]) begin
			res_word = OUT_W'({1'b0, 1'b1, {(2*W){1'b0}}});
		end else begin
			res_word = OUT_W'({qd_re[W] | qd_im[W], 1'b0, qd_im[W-1:0], qd_re[W-1:0]});
		end
	end

	logic [OUT_W-1:0] tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= res_word;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = tdata_q;

endmodule

// ----- hw/rtl/cau_div.sv -----
// Pipelined restoring divider: two numerators over a shared divisor, one quotient bit per stage.
module cau_div #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS,
	parameter int TAG_BITS = 1,
	localparam int NS = WORD_BITS + 2,
	localparam int MW = 2 * WORD_BITS + 1,
	localparam int DW = (MW + FRAC_BITS > 3 * WORD_BITS + 1) ? MW + FRAC_BITS
		: 3 * WORD_BITS + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic                     in_re_neg,
	input  logic [MW-1:0]            in_re_mag,
	input  logic                     in_im_neg,
	input  logic [MW-1:0]            in_im_mag,
	input  logic [2*WORD_BITS-1:0]   in_den,
	input  logic [TAG_BITS-1:0]      in_tag,
	output logic                     out_valid,
	output logic [NS-1:0]            out_re_quo,
	output logic                     out_re_neg,
	output logic [NS-1:0]            out_im_quo,
	output logic                     out_im_neg,
	output logic [TAG_BITS-1:0]      out_tag
);

	logic                   valid_s  [NS];
	logic [DW-1:0]          re_rem_s [NS];
	logic [DW-1:0]          im_rem_s [NS];
	logic [NS-1:0]          re_quo_s [NS];
	logic [NS-1:0]          im_quo_s [NS];
	logic                   re_neg_s [NS];
	logic                   im_neg_s [NS];
	logic [2*WORD_BITS-1:0] den_s    [NS];
	logic [TAG_BITS-1:0]    tag_s    [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		logic                   pv;
		logic [DW-1:0]          prr;
		logic [DW-1:0]          pir;
		logic [NS-1:0]          prq;
		logic [NS-1:0]          piq;
		logic                   prn;
		logic                   pin;
		logic [2*WORD_BITS-1:0] pden;
		logic [TAG_BITS-1:0]    ptag;
		logic [DW-1:0]          dsh;
		logic                   re_ge;
		logic                   im_ge;

		if (k == 0) begin : g_first
			assign pv   = in_valid;
			assign prr  = DW'(in_re_mag) << FRAC_BITS;
			assign pir  = DW'(in_im_mag) << FRAC_BITS;
			assign prq  = '0;
			assign piq  = '0;
			assign prn  = in_re_neg;
			assign pin  = in_im_neg;
			assign pden = in_den;
			assign ptag = in_tag;
		end else begin : g_next
			assign pv   = valid_s[k-1];
			assign prr  = re_rem_s[k-1];
			assign pir  = im_rem_s[k-1];
			assign prq  = re_quo_s[k-1];
			assign piq  = im_quo_s[k-1];
			assign prn  = re_neg_s[k-1];
			assign pin  = im_neg_s[k-1];
			assign pden = den_s[k-1];
			assign ptag = tag_s[k-1];
		end

		// divisor aligned to this stage's quotient bit
		assign dsh   = DW'(pden) << (NS - 1 - k);
		assign re_ge = (prr >= dsh);
		assign im_ge = (pir >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				re_rem_s[k] <= re_ge ? prr - dsh : prr;
				im_rem_s[k] <= im_ge ? pir - dsh : pir;
				re_quo_s[k] <= {prq[NS-2:0], re_ge};
				im_quo_s[k] <= {piq[NS-2:0], im_ge};
				re_neg_s[k] <= prn;
				im_neg_s[k] <= pin;
				den_s[k]    <= pden;
				tag_s[k]    <= ptag;
			end
		end
	end

	assign out_valid  = valid_s[NS-1];
	assign out_re_quo = re_quo_s[NS-1];
	assign out_re_neg = re_neg_s[NS-1];
	assign out_im_quo = im_quo_s[NS-1];
	assign out_im_neg = im_neg_s[NS-1];
	assign out_tag    = tag_s[NS-1];

endmodule

// ----- test/tb_complex_arithmetic_unit_core.sv -----
// Testbench for the complex arithmetic unit: random and directed operands checked against a predictor.
module tb_complex_arithmetic_unit_core;

	localparam int IN_W  = ((2 + 4 * cau_pkg::WORD_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((2 * cau_pkg::WORD_BITS + 2 + 7) / 8) * 8;
	localparam int N_RANDOM = 400;
	localparam int IDLE_LIMIT = 5000;
	localparam int LATENCY = cau_pkg::WORD_BITS + 5;

	// fields listed from the highest bits down, so op lands in bits [1:0]
	typedef struct packed {
		logic signed [15:0] b_im, b_re, a_im, a_re;
		logic [1:0] op;
	} operands_t;

	// fields listed from the highest bits down, so res_re lands in bits [15:0]
	typedef struct packed {
		logic saturated, div_by_zero;
		logic signed [15:0] res_im, res_re;
	} cplx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	complex_arithmetic_unit_core dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	operands_t pending_ops[$];
	cplx_result_t expected_results[$];
	int mismatches = 0;
	int n_sent = 0, n_checked = 0, n_dz = 0, n_sat = 0;
	int op_count[4] = '{0, 0, 0, 0};
	bit hold_sender = 1'b0;
	bit stim_done = 1'b0;
	int idle_cycles = 0;

	// Clip an exact value to the word range; flags clipping.
	function automatic logic signed [15:0] clip_word(input logic signed [63:0] v,
			inout logic sat);
		if (v > 64'sd32767) begin
			sat = 1'b1;
			return 16'sh7fff;
		end
		if (v < -64'sd32768) begin
			sat = 1'b1;
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Exact num * 2^FRAC / den, truncated toward zero.
	function automatic logic signed [63:0] frac_quotient(input logic signed [63:0] num,
			input logic [63:0] den);
		logic [63:0] mag;
		logic [63:0] q;
		mag = num < 0 ? -num : num;
		q = (mag << cau_pkg::FRAC_BITS) / den;
		if (q > 64'd1 << 40) q = 64'd1 << 40;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic cplx_result_t compute_complex(input operands_t x);
		cplx_result_t r;
		logic signed [63:0] ar, ai, br, bi, re, im, den;
		logic sat;
		ar = x.a_re;
		ai = x.a_im;
		br = x.b_re;
		bi = x.b_im;
		sat = 1'b0;
		r.div_by_zero = 1'b0;
		case (x.op)
			cau_pkg::OP_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			cau_pkg::OP_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			cau_pkg::OP_MUL: begin
				re = (ar * br - ai * bi) >>> cau_pkg::FRAC_BITS;
				im = (ar * bi + ai * br) >>> cau_pkg::FRAC_BITS;
			end
			default: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.div_by_zero = 1'b1;
					re = 0;
					im = 0;
				end else begin
					re = frac_quotient(ar * br + ai * bi, den);
					im = frac_quotient(ai * br - ar * bi, den);
				end
			end
		endcase
		r.res_re = clip_word(re, sat);
		r.res_im = clip_word(im, sat);
		r.saturated = sat;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 3));
			3: return 16'($signed($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void add_item(input logic [1:0] op, input logic signed [15:0] ar,
			input logic signed [15:0] ai, input logic signed [15:0] br,
			input logic signed [15:0] bi);
		operands_t x;
		x.op = op;
		x.a_re = ar;
		x.a_im = ai;
		x.b_re = br;
		x.b_im = bi;
		pending_ops.push_back(x);
	endfunction

	// Sender: bursts with random gaps; hold while hold_sender is set.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(compute_complex(operands_t'(s_axis_tdata[65:0])));
				n_sent <= n_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_ops.size() > 0 && !hold_sender) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {{(IN_W - 66){1'b0}}, pending_ops.pop_front()};
					if (burst_left > 0) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(0, 20);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern switches between free-running and random stalls.
	int stall_mode = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		cplx_result_t got, want;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[33:0];
				if (expected_results.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("unexpected result %h", got);
				end else begin
					want = expected_results.pop_front();
					n_checked <= n_checked + 1;
					if (want.div_by_zero) n_dz <= n_dz + 1;
					if (want.saturated) n_sat <= n_sat + 1;
					if (got !== want) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch #%0d: re %h/%h im %h/%h dz %b/%b sat %b/%b (exp/got)",
								n_checked, want.res_re, got.res_re, want.res_im, got.res_im,
								want.div_by_zero, got.div_by_zero, want.saturated, got.saturated);
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] op;
		// Directed: extremes, every op, zero divisor, saturation.
		for (int k = 0; k < 4; k++) begin
			op = k[1:0];
			add_item(op, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
			add_item(op, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
			add_item(op, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0000);
			add_item(op, 16'sh8000, 16'sh7fff, 16'sh0001, 16'shffff);
			add_item(op, 16'sh0180, 16'shff40, 16'sh0200, 16'sh0080);
		end
		add_item(cau_pkg::OP_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
		add_item(cau_pkg::OP_DIV, 16'shffff, 16'sh0001, 16'sh0300, 16'sh0000);
		add_item(cau_pkg::OP_MUL, 16'shffff, 16'sh0001, 16'sh0001, 16'sh0001);
		add_item(cau_pkg::OP_DIV, 16'sh1234, 16'sh5678, 16'sh0000, 16'sh0000);
		foreach (pending_ops[k]) op_count[pending_ops[k].op]++;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < N_RANDOM; n++) begin
			op = 2'($urandom_range(0, 3));
			op_count[op]++;
			add_item(op, rand_part(), rand_part(), rand_part(), rand_part());
			if (n == N_RANDOM / 2) begin
				// drain the pipeline once mid-run
				wait (pending_ops.size() == 0 && !s_axis_tvalid);
				hold_sender = 1'b1;
				wait (expected_results.size() == 0);
				@(posedge clk);
				hold_sender = 1'b0;
			end
		end
		wait (pending_ops.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("checked %0d results (add %0d, sub %0d, mul %0d, div %0d)",
			n_checked, op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("%0d zero divisors, %0d saturated results, %0d mismatches",
			n_dz, n_sat, mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
